// ----- rtl/pdu_pkg.sv -----
`default_nettype none

package pdu_pkg;

  // Decode modes held in the configuration register.
  typedef enum logic [1:0] {
    MODE_COMPONENT = 2'd0,
    MODE_URI       = 2'd1,
    MODE_LENIENT   = 2'd2,
    MODE_SPARE     = 2'd3
  } decode_mode_t;

  // Position inside a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  localparam logic [7:0] CHAR_PCT = 8'h25;

  localparam logic [20:0] CP_MIN_TWO   = 21'h00080;
  localparam logic [20:0] CP_MIN_THREE = 21'h00800;
  localparam logic [20:0] CP_SURR_LO   = 21'h0D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h0DFFF;
  localparam logic [20:0] CP_MIN_FOUR  = 21'h10000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  localparam int unsigned MAX_DATA    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Everything one input transfer produces, handed from the front to the back.
  typedef struct packed {
    logic [1:0]                n_data;
    logic [MAX_DATA-1:0][7:0]  data;
    logic                      has_status;
    logic                      malformed;
    logic [15:0]               count;
  } pdu_bundle_t;

  // Returns {valid, nibble} for an ASCII hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Reserved characters kept escaped in URI mode: # $ & + , / : ; = ? @
  function automatic logic is_uri_delim(input logic [7:0] c);
    return (c == 8'h23) || (c == 8'h24) || (c == 8'h26) || (c == 8'h2B) ||
           (c == 8'h2C) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3B) ||
           (c == 8'h3D) || (c == 8'h3F) || (c == 8'h40);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pdu_in_if.sv -----
`default_nettype none

interface pdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- rtl/pdu_out_if.sv -----
`default_nettype none

interface pdu_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  out_byte;
  logic        malformed;
  logic [15:0] out_count;
  logic        run_last;

  modport source (output valid, output record_kind, output out_byte, output malformed,
                  output out_count, output run_last, input ready);
  modport sink   (input valid, input record_kind, input out_byte, input malformed,
                  input out_count, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/percent_decode_utf8_check_unit.sv -----
// A byte's results are registered in the front-to-back queue and offered from there.
// Throughput: one byte per cycle while each byte yields at most one result and out_ch
// is ready; the back-end sequencer plays out all results of a byte before the next byte's.
// Reset: synchronous, active low; clears the decode mode to strict component decoding,
// all per-string state and the queue between front and back end.
`default_nettype none

module percent_decode_utf8_check_unit import pdu_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pdu_in_if.sink           in_ch,
  pdu_out_if.source        out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data
);

  // The front end takes one byte per transfer and works out, in that same cycle,
  // every result the byte causes: decoded data bytes (up to three) and, on the
  // last byte of a string, the status record with the sticky error flag and the
  // saturating byte count. The whole set goes into a short queue as one entry.
  // The back end then plays an entry out one result per cycle, so a slow
  // consumer stalls the back end alone until the queue fills.

  pdu_bundle_t push_data;
  pdu_bundle_t head;
  logic        push, q_full, pop, q_empty;

  pdu_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push_data   (push_data),
    .push        (push)
  );

  // Two entries let a byte be taken in the same cycle as the previous one's
  // results are still being handed over.
  pdu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // The back end flags the final result of each byte's set with run_last and
  // frees the queue entry on that result's transfer.
  pdu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/pdu_front.sv -----
`default_nettype none

module pdu_front import pdu_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pdu_in_if.sink           in_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        q_full,
  output pdu_bundle_t      push_data,
  output logic             push
);

  decode_mode_t           mode_r;
  esc_phase_t             esc_r, esc_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [3:0]             hi_r, hi_nxt;
  logic [1:0]             cont_r, cont_nxt;
  logic [1:0]             seql_r, seql_nxt;
  logic [20:0]            cp_r, cp_nxt;
  logic                   err_r, err_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic [4:0]             hx;
  logic [7:0]             b;
  logic [7:0]             dec;
  logic [20:0]            cp_shift;
  logic                   lenient, uri, last, accept;
  logic [1:0]             nd;
  logic [MAX_DATA-1:0][7:0] dat;
  logic                   bad_range;
  logic [COUNT_BITS+1:0]  cnt_sum;
  logic [COUNT_BITS-1:0]  cnt_sat;
  logic [COUNT_BITS+15:0] cnt_ext;

  assign b        = in_ch.in_byte;
  assign last     = in_ch.end_of_string;
  assign hx       = hex_val(b);
  assign dec      = {hi_r, hx[3:0]};
  assign cp_shift = {cp_r[14:0], dec[5:0]};
  assign lenient  = (mode_r == MODE_LENIENT);
  assign uri      = (mode_r == MODE_URI);
  assign in_ch.ready = !q_full;
  assign accept   = in_ch.valid && !q_full;

  always_comb begin
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    hi_nxt    = hi_r;
    cont_nxt  = cont_r;
    seql_nxt  = seql_r;
    cp_nxt    = cp_r;
    err_nxt   = err_r;
    nd        = 2'd0;
    dat       = '0;
    bad_range = 1'b0;

    if (lenient) begin
      unique case (esc_r)
        ESC_NONE: begin
          if (b == CHAR_PCT) begin
            esc_nxt = ESC_PCT;
          end else begin
            dat[nd] = b; nd = nd + 2'd1;
          end
        end
        ESC_PCT: begin
          if (hx[4]) begin
            held_nxt = b;
            hi_nxt   = hx[3:0];
            esc_nxt  = ESC_DIGIT;
          end else begin
            dat[nd] = CHAR_PCT; nd = nd + 2'd1;
            if (b == CHAR_PCT) begin
              esc_nxt = ESC_PCT;
            end else begin
              esc_nxt = ESC_NONE;
              dat[nd] = b; nd = nd + 2'd1;
            end
          end
        end
        default: begin
          esc_nxt = ESC_NONE;
          if (hx[4]) begin
            dat[nd] = dec; nd = nd + 2'd1;
          end else begin
            dat[nd] = CHAR_PCT; nd = nd + 2'd1;
            dat[nd] = held_r;   nd = nd + 2'd1;
            if (b == CHAR_PCT) begin
              esc_nxt = ESC_PCT;
            end else begin
              dat[nd] = b; nd = nd + 2'd1;
            end
          end
        end
      endcase
    end else if (!err_r) begin
      unique case (esc_r)
        ESC_NONE: begin
          if (b == CHAR_PCT) begin
            esc_nxt = ESC_PCT;
          end else if (cont_r != 2'd0) begin
            err_nxt = 1'b1; esc_nxt = ESC_NONE; cont_nxt = 2'd0;
          end else begin
            dat[nd] = b; nd = nd + 2'd1;
          end
        end
        ESC_PCT: begin
          if (!hx[4]) begin
            err_nxt = 1'b1; esc_nxt = ESC_NONE; cont_nxt = 2'd0;
          end else begin
            held_nxt = b;
            hi_nxt   = hx[3:0];
            esc_nxt  = ESC_DIGIT;
          end
        end
        default: begin
          if (!hx[4]) begin
            err_nxt = 1'b1; esc_nxt = ESC_NONE; cont_nxt = 2'd0;
          end else begin
            esc_nxt = ESC_NONE;
            if (cont_r != 2'd0) begin
              if (dec[7:6] != 2'b10) begin
                err_nxt = 1'b1; cont_nxt = 2'd0;
              end else begin
                dat[nd]  = dec; nd = nd + 2'd1;
                cp_nxt   = cp_shift;
                cont_nxt = cont_r - 2'd1;
                if (cont_r == 2'd1) begin
                  unique case (seql_r)
                    2'd1:    bad_range = (cp_shift < CP_MIN_TWO);
                    2'd2:    bad_range = (cp_shift < CP_MIN_THREE) ||
                                         ((cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI));
                    2'd3:    bad_range = (cp_shift < CP_MIN_FOUR) || (cp_shift > CP_MAX);
                    default: bad_range = 1'b0;
                  endcase
                  if (bad_range) begin
                    err_nxt = 1'b1; cont_nxt = 2'd0;
                  end
                end
              end
            end else if (uri && is_uri_delim(dec)) begin
              dat[nd] = CHAR_PCT; nd = nd + 2'd1;
              dat[nd] = held_r;   nd = nd + 2'd1;
              dat[nd] = b;        nd = nd + 2'd1;
            end else if (!dec[7]) begin
              dat[nd] = dec; nd = nd + 2'd1;
            end else if (dec[7:5] == 3'b110) begin
              seql_nxt = 2'd1; cont_nxt = 2'd1; cp_nxt = {16'd0, dec[4:0]};
              dat[nd] = dec; nd = nd + 2'd1;
            end else if (dec[7:4] == 4'b1110) begin
              seql_nxt = 2'd2; cont_nxt = 2'd2; cp_nxt = {17'd0, dec[3:0]};
              dat[nd] = dec; nd = nd + 2'd1;
            end else if (dec[7:3] == 5'b11110) begin
              seql_nxt = 2'd3; cont_nxt = 2'd3; cp_nxt = {18'd0, dec[2:0]};
              dat[nd] = dec; nd = nd + 2'd1;
            end else begin
              err_nxt = 1'b1; cont_nxt = 2'd0;
            end
          end
        end
      endcase
    end

    // An escape, or in the strict modes an open UTF-8 sequence, cut short by the end of the string.
    if (last) begin
      if (lenient) begin
        if (esc_nxt == ESC_PCT) begin
          dat[nd] = CHAR_PCT; nd = nd + 2'd1;
        end else if (esc_nxt == ESC_DIGIT) begin
          dat[nd] = CHAR_PCT; nd = nd + 2'd1;
          dat[nd] = held_nxt; nd = nd + 2'd1;
        end
      end else if (!err_nxt && ((esc_nxt != ESC_NONE) || (cont_nxt != 2'd0))) begin
        err_nxt = 1'b1;
      end
    end

    cnt_sum = {2'b00, cnt_r} + {{COUNT_BITS{1'b0}}, nd};
    if (cnt_sum > {2'b00, {COUNT_BITS{1'b1}}}) begin
      cnt_sat = {COUNT_BITS{1'b1}};
    end else begin
      cnt_sat = cnt_sum[COUNT_BITS-1:0];
    end
    cnt_ext = {16'd0, cnt_sat};
    cnt_nxt = cnt_sat;

    push_data.n_data     = nd;
    push_data.data       = dat;
    push_data.has_status = last;
    push_data.malformed  = err_nxt;
    push_data.count      = cnt_ext[15:0];

    if (last) begin
      esc_nxt  = ESC_NONE;
      held_nxt = 8'd0;
      hi_nxt   = 4'd0;
      cont_nxt = 2'd0;
      seql_nxt = 2'd0;
      cp_nxt   = 21'd0;
      err_nxt  = 1'b0;
      cnt_nxt  = '0;
    end
  end

  assign push = accept && (last || (nd != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COMPONENT;
      esc_r  <= ESC_NONE;
      held_r <= 8'd0;
      hi_r   <= 4'd0;
      cont_r <= 2'd0;
      seql_r <= 2'd0;
      cp_r   <= 21'd0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= decode_mode_t'(cfg_wr_data);
      end
      if (accept) begin
        esc_r  <= esc_nxt;
        held_r <= held_nxt;
        hi_r   <= hi_nxt;
        cont_r <= cont_nxt;
        seql_r <= seql_nxt;
        cp_r   <= cp_nxt;
        err_r  <= err_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pdu_queue.sv -----
`default_nettype none

module pdu_queue import pdu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire pdu_bundle_t push_data,
  output logic             full,
  input  wire logic        pop,
  output pdu_bundle_t      head,
  output logic             empty
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pdu_bundle_t        store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic               do_push, do_pop;

  assign full    = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pdu_back.sv -----
`default_nettype none

module pdu_back import pdu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pdu_bundle_t head,
  input  wire logic        empty,
  output logic             pop,
  pdu_out_if.source        out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_data, is_last, fire;

  assign total   = {1'b0, head.n_data} + {2'b00, head.has_status};
  assign is_data = (idx_r < head.n_data);
  assign is_last = (({1'b0, idx_r} + 3'd1) == total);
  assign fire    = !empty && out_ch.ready;
  assign pop     = fire && is_last;

  assign out_ch.valid       = !empty;
  assign out_ch.record_kind = !is_data;
  assign out_ch.out_byte    = is_data ? head.data[idx_r] : 8'd0;
  assign out_ch.malformed   = is_data ? 1'b0 : head.malformed;
  assign out_ch.out_count   = is_data ? 16'd0 : head.count;
  assign out_ch.run_last    = is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdu_pkg::*;

  // Run limits. The cycle limit allows for every character yielding its most records while
  // the receiver sits in its longest stall and the sender in its longest gap, several times over.
  localparam int unsigned CNT_MAX       = 65535;
  localparam int          ITEM_TARGET   = 460;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          CYCLE_LIMIT   = 400000;

  // Characters whose escapes stay as written in URI mode.
  localparam logic [7:0] RESERVED_CHARS [11] = '{"#", "$", "&", "+", ",", "/", ":", ";", "=",
                                                 "?", "@"};

  // One record on the result channel, in the order of the output fields.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        mal;
    logic [15:0] cnt;
    logic        last;
  } record_t;

  // One row of the directed stimulus. Where cfg is set, the decoder is drained and the mode
  // written before the character goes in. Where typed is set, the status record of that
  // character is expected with the malformed flag and count given in the row.
  typedef struct packed {
    logic         cfg;
    decode_mode_t mode;
    logic [7:0]   chr;
    logic         eos;
    logic         typed;
    logic         mal;
    logic [15:0]  cnt;
  } directed_row_t;

  directed_row_t directed [25] = '{
    // Lowest and highest plain byte, each a string of its own, straight after reset.
    '{1'b0, MODE_COMPONENT, 8'h00,    1'b1, 1'b1, 1'b0, 16'd1},
    '{1'b0, MODE_COMPONENT, 8'hFF,    1'b1, 1'b1, 1'b0, 16'd1},
    // An escape cut short by the end of the string is an error in strict mode.
    '{1'b0, MODE_COMPONENT, CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "4",      1'b1, 1'b1, 1'b1, 16'd0},
    // A lone continuation byte cannot lead a sequence.
    '{1'b0, MODE_COMPONENT, CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "8",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "0",      1'b1, 1'b1, 1'b1, 16'd0},
    // Overlong two-byte form: both bytes go out, then the range check flags the string.
    // The final escape also ends exactly on the last character.
    '{1'b0, MODE_COMPONENT, CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "c",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "0",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "8",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_COMPONENT, "0",      1'b1, 1'b1, 1'b1, 16'd2},
    // URI mode keeps an escaped slash as the three characters written.
    '{1'b1, MODE_URI,       CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_URI,       "2",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_URI,       "F",      1'b1, 1'b1, 1'b0, 16'd3},
    // Lenient mode: a bad escape passes literally, and a cut escape is flushed at the end.
    '{1'b1, MODE_LENIENT,   CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_LENIENT,   "z",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_LENIENT,   "q",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_LENIENT,   CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_LENIENT,   "4",      1'b1, 1'b1, 1'b0, 16'd5},
    // The spare mode decodes strictly; the string is then finished in lenient mode, which
    // ignores the three-byte sequence left open.
    '{1'b1, MODE_SPARE,     CHAR_PCT, 1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_SPARE,     "E",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b0, MODE_SPARE,     "2",      1'b0, 1'b0, 1'b0, 16'd0},
    '{1'b1, MODE_LENIENT,   "A",      1'b1, 1'b1, 1'b0, 16'd2}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  pdu_in_if  in_ch ();
  pdu_out_if out_ch ();

  percent_decode_utf8_check_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Decoder state as the checker sees it, plus the mode register.
  decode_mode_t dec_mode;
  esc_phase_t   esc;
  logic [7:0]   held_char;
  logic [3:0]   hi_nib;
  logic [1:0]   cont_left;
  logic [1:0]   seq_len;
  logic [20:0]  cp_acc;
  logic         err_flag;
  int unsigned  out_total;

  record_t    step_recs [$];
  record_t    expected_q [$];
  logic [7:0] text_q [$];
  logic [7:0] utf_q [$];

  record_t seen_rec;
  record_t due_rec;
  int      errors = 0;
  int      counted_chars = 0;
  int      cycle_count = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Clock, and a guard against a run that hangs.
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Decoder prediction.
  // ---------------------------------------------------------------------------------------
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic bit keeps_escape(input logic [7:0] c);
    foreach (RESERVED_CHARS[i]) begin
      if (RESERVED_CHARS[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // The byte count goes on rising after the fourth record of a step, which cannot be shown.
  task automatic emit_data(input logic [7:0] d);
    if (step_recs.size() < 4) step_recs.push_back('{1'b0, d, 1'b0, 16'd0, 1'b0});
    if (out_total < CNT_MAX) out_total++;
  endtask

  task automatic flag_error();
    err_flag  = 1'b1;
    esc       = ESC_NONE;
    cont_left = 2'd0;
  endtask

  // Overlong forms, surrogates and code points beyond the Unicode range.
  task automatic check_range();
    bit bad;
    bad = 1'b0;
    case (seq_len)
      2'd1: bad = cp_acc < 21'h80;
      2'd2: bad = cp_acc < 21'h800 || (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF);
      2'd3: bad = cp_acc < 21'h10000 || cp_acc > 21'h10FFFF;
      default: bad = 1'b0;
    endcase
    if (bad) flag_error();
  endtask

  task automatic strict_value(input logic [7:0] v, input logic [7:0] last_char, input bit uri);
    if (cont_left > 0) begin
      if (v[7:6] != 2'b10) begin
        flag_error();
        return;
      end
      emit_data(v);
      cp_acc = {cp_acc[14:0], v[5:0]};
      cont_left--;
      if (cont_left == 0) check_range();
      return;
    end
    if (uri && keeps_escape(v)) begin
      emit_data(CHAR_PCT);
      emit_data(held_char);
      emit_data(last_char);
      return;
    end
    if (v < 8'h80) begin
      emit_data(v);
      return;
    end
    if (v[7:5] == 3'b110) begin
      seq_len = 2'd1;
      cp_acc  = {16'd0, v[4:0]};
    end else if (v[7:4] == 4'b1110) begin
      seq_len = 2'd2;
      cp_acc  = {17'd0, v[3:0]};
    end else if (v[7:3] == 5'b11110) begin
      seq_len = 2'd3;
      cp_acc  = {18'd0, v[2:0]};
    end else begin
      flag_error();
      return;
    end
    cont_left = seq_len;
    emit_data(v);
  endtask

  task automatic strict_char(input logic [7:0] b, input bit uri);
    int h;
    h = hex_nibble(b);
    if (err_flag) return;
    case (esc)
      ESC_NONE: begin
        if (b == CHAR_PCT) esc = ESC_PCT;
        else if (cont_left > 0) flag_error();
        else emit_data(b);
      end
      ESC_PCT: begin
        if (h < 0) begin
          flag_error();
        end else begin
          held_char = b;
          hi_nib    = h[3:0];
          esc       = ESC_DIGIT;
        end
      end
      default: begin
        if (h < 0) begin
          flag_error();
        end else begin
          esc = ESC_NONE;
          strict_value({hi_nib, h[3:0]}, b, uri);
        end
      end
    endcase
  endtask

  task automatic plain_lenient(input logic [7:0] b);
    if (b == CHAR_PCT) esc = ESC_PCT;
    else emit_data(b);
  endtask

  task automatic lenient_char(input logic [7:0] b);
    int h;
    h = hex_nibble(b);
    case (esc)
      ESC_NONE: plain_lenient(b);
      ESC_PCT: begin
        if (h >= 0) begin
          held_char = b;
          hi_nib    = h[3:0];
          esc       = ESC_DIGIT;
        end else begin
          emit_data(CHAR_PCT);
          esc = ESC_NONE;
          plain_lenient(b);
        end
      end
      default: begin
        esc = ESC_NONE;
        if (h >= 0) begin
          emit_data({hi_nib, h[3:0]});
        end else begin
          emit_data(CHAR_PCT);
          emit_data(held_char);
          plain_lenient(b);
        end
      end
    endcase
  endtask

  task automatic clear_text_state();
    esc       = ESC_NONE;
    held_char = 8'h00;
    hi_nib    = 4'h0;
    cont_left = 2'd0;
    seq_len   = 2'd0;
    cp_acc    = 21'd0;
    err_flag  = 1'b0;
    out_total = 0;
  endtask

  // Works out the records that one accepted character causes and queues them.
  task automatic predict_char(input logic [7:0] b, input bit eos, input bit typed,
                              input bit tmal, input logic [15:0] tcnt);
    record_t st;
    bit      lenient;
    lenient = (dec_mode == MODE_LENIENT);
    counted_chars++;
    step_recs.delete();
    if (lenient) lenient_char(b);
    else strict_char(b, dec_mode == MODE_URI);
    if (eos) begin
      if (lenient) begin
        if (esc == ESC_PCT) begin
          emit_data(CHAR_PCT);
        end else if (esc == ESC_DIGIT) begin
          emit_data(CHAR_PCT);
          emit_data(held_char);
        end
      end else if (!err_flag && (esc != ESC_NONE || cont_left > 0)) begin
        flag_error();
      end
      st = '{1'b1, 8'h00, err_flag, out_total[15:0], 1'b0};
      if (typed) begin
        st.mal = tmal;
        st.cnt = tcnt;
      end
      if (step_recs.size() < 4) step_recs.push_back(st);
      clear_text_state();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) expected_q.push_back(step_recs[i]);
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus generation. Escapes are built with hex digits of random case.
  // ---------------------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    if ($urandom_range(0, 1) == 0) return 8'("A" + n - 10);
    return 8'("a" + n - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  // A code point that is legal for an encoding of the given length, surrogates aside.
  function automatic logic [20:0] valid_cp(input int len);
    case (len)
      1:       return 21'($urandom_range(0, 'h7F));
      2:       return 21'($urandom_range('h80, 'h7FF));
      3:       return 21'($urandom_range('h800, 'hFFFF));
      default: return 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  task automatic add_escape(input logic [7:0] v);
    text_q.push_back(CHAR_PCT);
    text_q.push_back(hex_char(v[7:4]));
    text_q.push_back(hex_char(v[3:0]));
  endtask

  // Encodes cp into utf_q with exactly len bytes, whether or not that is the shortest form.
  task automatic fill_utf(input logic [20:0] cp, input int len);
    utf_q.delete();
    case (len)
      1: utf_q.push_back({1'b0, cp[6:0]});
      2: begin
        utf_q.push_back({3'b110, cp[10:6]});
        utf_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        utf_q.push_back({4'b1110, cp[15:12]});
        utf_q.push_back({2'b10, cp[11:6]});
        utf_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        utf_q.push_back({5'b11110, cp[20:18]});
        utf_q.push_back({2'b10, cp[17:12]});
        utf_q.push_back({2'b10, cp[11:6]});
        utf_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_utf_escapes();
    foreach (utf_q[i]) add_escape(utf_q[i]);
  endtask

  // Mostly plain text and well-formed escaped UTF-8, with a share of each way to break it.
  task automatic add_piece();
    int         r;
    int         k;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      c = 8'($urandom_range(32, 126));
      if (c == CHAR_PCT) c = "~";
      text_q.push_back(c);
    end else if (r < 30) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 62) begin
      k = $urandom_range(1, 4);
      fill_utf(valid_cp(k), k);
      add_utf_escapes();
    end else if (r < 70) begin
      add_escape(RESERVED_CHARS[$urandom_range(0, 10)]);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: begin
          // Overlong: a code point of a shorter class in a longer form.
          k = $urandom_range(2, 4);
          fill_utf(valid_cp(k - 1), k);
        end
        1: fill_utf(21'($urandom_range('hD800, 'hDFFF)), 3);
        2: fill_utf(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        default: begin
          utf_q.delete();
          if ($urandom_range(0, 1) == 0) utf_q.push_back(8'($urandom_range('h80, 'hBF)));
          else utf_q.push_back(8'($urandom_range('hF8, 'hFF)));
        end
      endcase
      add_utf_escapes();
    end else if (r < 90) begin
      // A sequence that is cut short, has a bad continuation or has plain text inside.
      k = $urandom_range(2, 4);
      fill_utf(valid_cp(k), k);
      case ($urandom_range(0, 2))
        0: begin
          void'(utf_q.pop_back());
          add_utf_escapes();
        end
        1: begin
          utf_q[utf_q.size() - 1] = 8'($urandom_range(0, 127)) |
                                    (($urandom_range(0, 1) == 0) ? 8'hC0 : 8'h00);
          add_utf_escapes();
        end
        default: begin
          c = utf_q.pop_back();
          add_utf_escapes();
          text_q.push_back(8'($urandom_range("A", "Z")));
          add_escape(c);
        end
      endcase
    end else begin
      text_q.push_back(CHAR_PCT);
      case ($urandom_range(0, 3))
        0: text_q.push_back(non_hex());
        1: begin
          text_q.push_back(hex_char(4'($urandom_range(0, 15))));
          text_q.push_back(non_hex());
        end
        2: text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        default: ;
      endcase
    end
  endtask

  task automatic build_text();
    int n;
    text_q.delete();
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
    repeat (n) add_piece();
  endtask

  // ---------------------------------------------------------------------------------------
  // Idling. Mostly no gap, sometimes a short one, now and then a long one; none at all
  // while a quiet stretch is running.
  // ---------------------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge, where the inputs change.
  // ---------------------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] b, input bit eos, input bit typed,
                           input bit tmal, input logic [15:0] tcnt);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.in_byte       = b;
    in_ch.end_of_string = eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_char(b, eos, typed, tmal, tcnt);
    @(negedge clk);
  endtask

  // Waits until every expected record has arrived and then lets the decoder settle, so that
  // it is idle afterwards.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input decode_mode_t m);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    dec_mode    = m;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Sends text_q as one string. Now and then the mode is changed part-way through, with the
  // decoder drained first so that the write lands while it is idle.
  task automatic send_text();
    int split;
    split = 0;
    if ($urandom_range(0, 9) == 0 && text_q.size() > 1) begin
      split = $urandom_range(1, text_q.size() - 1);
    end
    foreach (text_q[i]) begin
      if (split != 0 && i == split) begin
        settle();
        set_mode(decode_mode_t'($urandom_range(0, 3)));
      end
      send_char(text_q[i], i == text_q.size() - 1, 1'b0, 1'b0, 16'd0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver side: random stalls, and on request one long hold-off counted here, during
  // which the sender keeps offering characters until the decoder backs up.
  // ---------------------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_len();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  // Each record transferred is compared with the oldest one expected.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_rec = '{out_ch.record_kind, out_ch.out_byte, out_ch.malformed, out_ch.out_count,
                   out_ch.run_last};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: record with none expected: kind=%0d byte=%02h malformed=%0d",
                 $time, seen_rec.kind, seen_rec.data, seen_rec.mal);
        $display("%0t:          count=%0d last=%0d", $time, seen_rec.cnt, seen_rec.last);
      end else begin
        due_rec = expected_q.pop_front();
        if (seen_rec !== due_rec) begin
          errors++;
          $display("%0t: mismatch, expected kind=%0d byte=%02h malformed=%0d count=%0d last=%0d",
                   $time, due_rec.kind, due_rec.data, due_rec.mal, due_rec.cnt, due_rec.last);
          $display("%0t:          actual   kind=%0d byte=%02h malformed=%0d count=%0d last=%0d",
                   $time, seen_rec.kind, seen_rec.data, seen_rec.mal, seen_rec.cnt,
                   seen_rec.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    int phase_no;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = MODE_COMPONENT;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_string = 1'b0;
    dec_mode            = MODE_COMPONENT;
    clear_text_state();

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: the mode starts at its reset value, strict component decoding.
    foreach (directed[i]) begin
      if (directed[i].cfg) begin
        settle();
        set_mode(directed[i].mode);
      end
      send_char(directed[i].chr, directed[i].eos, directed[i].typed, directed[i].mal,
                directed[i].cnt);
    end

    // Back-pressure: the receiver holds off while a long plain string is sent without gaps,
    // so the decoder fills and has to stall its input.
    settle();
    set_mode(MODE_COMPONENT);
    quiet    = 1'b1;
    hold_req = 1'b1;
    text_q.delete();
    repeat (30) text_q.push_back(8'($urandom_range("a", "z")));
    send_text();
    quiet = 1'b0;

    // Random part, in phases. The first four phases walk through every mode, after which
    // the mode is picked at random; some phases run with no idling on either side.
    phase_no = 0;
    while (counted_chars < ITEM_TARGET) begin
      settle();
      set_mode((phase_no < 4) ? decode_mode_t'(phase_no) : decode_mode_t'($urandom_range(0, 3)));
      quiet = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(3, 8)) begin
        build_text();
        send_text();
      end
      quiet = 1'b0;
      phase_no++;
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- percent_decode_utf8_check_unit.f -----
rtl/pdu_pkg.sv
rtl/pdu_in_if.sv
rtl/pdu_out_if.sv
rtl/pdu_front.sv
rtl/pdu_queue.sv
rtl/pdu_back.sv
rtl/percent_decode_utf8_check_unit.sv
verif/tb_top.sv
